### design/fdte_pkg.sv
package fdte_pkg;

    localparam logic [15:0] DaysBefore1980 = 16'd3652;
    localparam logic [15:0] DaysPerYear    = 16'd365;
    localparam logic [6:0]  Offset2100     = 7'd120;
    localparam logic [31:0] SecsPerDay     = 32'd86400;
    localparam logic [16:0] SecsPerHour    = 17'd3600;
    localparam logic [16:0] SecsPerMin     = 17'd60;

    localparam logic [3:0] MonJan = 4'd1;
    localparam logic [3:0] MonFeb = 4'd2;
    localparam logic [3:0] MonDec = 4'd12;

    // Fields after decode: day count split into parts, raw time fields.
    typedef struct packed {
        logic        zero;
        logic [15:0] year_days;
        logic [8:0]  month_days;
        logic [4:0]  day_m1;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [4:0]  sec2;
    } t_dec;

    typedef struct packed {
        logic        zero;
        logic [15:0] days;
        logic [16:0] tod_secs;
    } t_sum;

    // Days in the whole months before month m (month already clamped to 1..12).
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### design/fdte_decode.sv
module fdte_decode
    import fdte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [15:0] i_date_word,
    input  logic [15:0] i_time_word,
    output logic        o_valid,
    output t_dec        o_dec
);

    logic [6:0]  year_ofs;
    logic [3:0]  month_raw;
    logic [3:0]  month;
    logic [4:0]  day_raw;
    logic [7:0]  ofs_p3;
    logic [5:0]  leap_cnt;
    logic        is_leap;
    logic        past_2100;
    logic [15:0] year_days;
    logic [8:0]  month_days;
    t_dec        n_dec;
    t_dec        r_dec;
    logic        r_valid;

    assign year_ofs  = i_date_word[15:9];
    assign month_raw = i_date_word[8:5];
    assign day_raw   = i_date_word[4:0];

    always_comb begin
        priority if (month_raw < MonJan) begin
            month = MonJan;
        end else if (month_raw > MonDec) begin
            month = MonDec;
        end else begin
            month = month_raw;
        end
    end

    // Leap years from 1980 on: every fourth, except 2100.
    assign ofs_p3     = {1'b0, year_ofs} + 8'd3;
    assign past_2100  = (year_ofs > Offset2100);
    assign leap_cnt   = ofs_p3[7:2] - {5'd0, past_2100};
    assign is_leap    = (year_ofs[1:0] == 2'd0) && (year_ofs != Offset2100);
    assign year_days  = DaysBefore1980 + 16'(16'(year_ofs) * DaysPerYear)
                        + {10'd0, leap_cnt};
    assign month_days = days_before_month(month) + {8'd0, (is_leap && month > MonFeb)};

    always_comb begin
        n_dec.zero       = (i_date_word == 16'd0);
        n_dec.year_days  = year_days;
        n_dec.month_days = month_days;
        n_dec.day_m1     = (day_raw == 5'd0) ? 5'd0 : day_raw - 5'd1;
        n_dec.hour       = i_time_word[15:11];
        n_dec.minute     = i_time_word[10:5];
        n_dec.sec2       = i_time_word[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

### design/fdte_sum.sv
module fdte_sum
    import fdte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_dec i_dec,
    output logic o_valid,
    output t_sum o_sum
);

    t_sum n_sum;
    t_sum r_sum;
    logic r_valid;

    always_comb begin
        n_sum.zero     = i_dec.zero;
        n_sum.days     = i_dec.year_days + {7'd0, i_dec.month_days}
                         + {11'd0, i_dec.day_m1};
        n_sum.tod_secs = 17'(17'(i_dec.hour) * SecsPerHour)
                         + 17'(17'(i_dec.minute) * SecsPerMin)
                         + {11'd0, i_dec.sec2, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

### design/fdte_scale.sv
module fdte_scale
    import fdte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en_mul,
    input  logic        i_en_out,
    input  logic        i_valid,
    input  t_sum        i_sum,
    output logic        o_mul_valid,
    output logic        o_valid,
    output logic [31:0] o_epoch_seconds
);

    logic        r_mul_valid;
    logic        r_mul_zero;
    logic [31:0] r_day_secs;
    logic [16:0] r_tod_secs;
    logic        r_valid;
    logic [31:0] r_result;
    logic [31:0] n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (i_en_mul) begin
                r_mul_valid <= i_valid;
            end
            if (i_en_out) begin
                r_valid <= r_mul_valid;
            end
        end
    end

    // Day count times seconds per day, kept modulo 2^32.
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_mul_zero <= i_sum.zero;
            r_day_secs <= 32'(32'(i_sum.days) * SecsPerDay);
            r_tod_secs <= i_sum.tod_secs;
        end
    end

    assign n_result = r_mul_zero ? 32'd0 : r_day_secs + {15'd0, r_tod_secs};

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_result <= n_result;
        end
    end

    assign o_mul_valid     = r_mul_valid;
    assign o_valid         = r_valid;
    assign o_epoch_seconds = r_result;

endmodule

### design/fat_datetime_to_epoch_seconds_top.sv
// FAT date/time to seconds since 1970-01-01.
//
// Input channel: i_valid, i_date_word, i_time_word, with o_stall back to the
// sender. A transfer happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid, o_epoch_seconds, with i_stall from the receiver.
// One result leaves for every input transfer, in order.
//
// Four register stages: field decode and year/month day counts, day and
// time-of-day sums, day-to-seconds multiply, final add into the output
// register. A word pair moves through these stage registers in that order;
// while i_stall stays low the block takes one word pair per cycle. The
// multiply gets a stage of its own, which sets the depth at four.
//
// A stalled stage holds its contents; an empty stage keeps accepting, so
// bubbles close up while the receiver stalls. o_stall rises only once all
// four stages are full and i_stall is high. A stalled result holds steady.
// Reset (synchronous, active low) empties every stage; payload registers
// are not cleared.
module fat_datetime_to_epoch_seconds_top
    import fdte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_date_word,
    input  logic [15:0] i_time_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_epoch_seconds
);

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic v1;
    logic v2;
    logic v3;
    t_dec dec;
    t_sum sum;

    // Advance a stage when it is empty or the next stage advances.
    assign en4     = !o_valid || !i_stall;
    assign en3     = !v3 || en4;
    assign en2     = !v2 || en3;
    assign en1     = !v1 || en2;
    assign o_stall = !en1;

    fdte_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en1),
        .i_valid     (i_valid),
        .i_date_word (i_date_word),
        .i_time_word (i_time_word),
        .o_valid     (v1),
        .o_dec       (dec)
    );

    fdte_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (v1),
        .i_dec   (dec),
        .o_valid (v2),
        .o_sum   (sum)
    );

    fdte_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en_mul        (en3),
        .i_en_out        (en4),
        .i_valid         (v2),
        .i_sum           (sum),
        .o_mul_valid     (v3),
        .o_valid         (o_valid),
        .o_epoch_seconds (o_epoch_seconds)
    );

endmodule

### test/tb.sv
// Testbench for fat_datetime_to_epoch_seconds_top.
//
// Every accepted date/time pair is run through a behavioral converter, and the
// expected seconds are queued in transfer order. A monitor pops the oldest
// entry for each output transfer and compares it with o_epoch_seconds.
//
// The named test tasks are called in turn from one initial block:
//   - zero date
//   - field extremes
//   - month clamping
//   - day zero and day rollover
//   - leap-year rules
//   - out-of-range time fields
//   - 32-bit wraparound
//   - a long random run
//
// Both sides idle in random bursts. The sender drops i_valid between
// transfers, and the receiver raises i_stall. The last part of the random run
// has no idling at all.
//
// A watchdog ends the run if nothing transfers for too long.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdte_pkg::*;

    // Longest quiet stretch in a correct run is one sender gap plus one
    // receiver stall plus the trip through the pipeline; allow many times that.
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned SEGMENT_LEN    = 61;
    localparam int unsigned SEGMENT_COUNT  = 30;
    localparam int unsigned QUIET_SEGMENTS = 3;
    localparam int unsigned EPOCH_YEAR     = 1970;
    localparam int unsigned FAT_BASE_YEAR  = 1980;
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [15:0] i_date_word = 16'h0000;
    logic [15:0] i_time_word = 16'h0000;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [31:0] o_epoch_seconds;

    // One outstanding conversion: the inputs are kept for the mismatch report.
    typedef struct {
        logic [15:0] date_w;
        logic [15:0] time_w;
        logic [31:0] epoch;
    } t_conversion;

    t_conversion pending_epochs[$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned gap_pct     = 0;   // chance of a sender gap after each transfer
    int unsigned stall_pct   = 0;   // chance per cycle that a receiver stall burst starts
    int unsigned stall_left  = 0;

    fat_datetime_to_epoch_seconds_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_date_word    (i_date_word),
        .i_time_word    (i_time_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_epoch_seconds(o_epoch_seconds)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Behavioral converter
    // ---------------------------------------------------------------------
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Work in 32-bit vectors, so the day-to-seconds product and the sums wrap
    // the way the hardware does.
    function automatic logic [31:0] fat_to_epoch(input logic [15:0] date_w,
                                                 input logic [15:0] time_w);
        int unsigned yr, mon, dd, y, m;
        logic [31:0] days;
        if (date_w == 16'h0000) begin
            return 32'd0;
        end
        yr  = FAT_BASE_YEAR + 32'(date_w[15:9]);
        mon = 32'(date_w[8:5]);
        dd  = 32'(date_w[4:0]);
        if (mon < MonJan) mon = MonJan;
        if (mon > MonDec) mon = MonDec;
        if (dd == 0) dd = 1;
        days = 32'd0;
        for (y = EPOCH_YEAR; y < yr; y++) begin
            days += is_leap(y) ? 366 : 365;
        end
        for (m = MonJan; m < mon; m++) begin
            days += (m == MonFeb && is_leap(yr)) ? 29 : MONTH_LEN[m - 1];
        end
        days += dd - 1;
        return days * SecsPerDay + time_w[15:11] * SecsPerHour
             + time_w[10:5] * SecsPerMin + {time_w[4:0], 1'b0};
    endfunction

    function automatic logic [15:0] pack_date(input int unsigned yoff, mon, dd);
        return {yoff[6:0], mon[3:0], dd[4:0]};
    endfunction

    function automatic logic [15:0] pack_time(input int unsigned hr, mi, s2);
        return {hr[4:0], mi[5:0], s2[4:0]};
    endfunction

    // Count every failure, and print only the first ten.
    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender: call at a falling edge; returns at a falling edge.
    // Valid stays high into the next call unless a gap is taken here, so it
    // is never lowered and raised again in one step.
    // ---------------------------------------------------------------------
    task automatic send_pair(input logic [15:0] date_w, input logic [15:0] time_w);
        int unsigned gap;
        i_valid     <= 1'b1;
        i_date_word <= date_w;
        i_time_word <= time_w;
        // Hold the payload until the block takes it.
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_epochs.push_back('{date_w, time_w, fat_to_epoch(date_w, time_w)});
        @(negedge i_clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Receiver back-pressure: random bursts of stalled cycles.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 14);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result monitor: each output transfer must match the oldest expectation.
    always @(posedge i_clk) begin
        t_conversion want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_epochs.size() == 0) begin
                note_error($sformatf("unexpected result %0d", o_epoch_seconds));
            end else begin
                want = pending_epochs.pop_front();
                if (o_epoch_seconds !== want.epoch) begin
                    note_error($sformatf("date %h time %h: expected %0d, got %0d",
                                         want.date_w, want.time_w, want.epoch,
                                         o_epoch_seconds));
                end
            end
        end
    end

    // Watchdog: reset the count on any transfer, on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------------

    // A zero date gives zero, whatever the time word holds.
    task automatic test_zero_date;
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h0000, 16'hFFFF);
    endtask

    task automatic test_field_extremes;
        send_pair(pack_date(0, 1, 1), 16'h0000);            // 1980-01-01 midnight
        send_pair(pack_date(127, 12, 31), pack_time(23, 59, 29));
        send_pair(16'hFFFF, 16'hFFFF);                      // every bit set
        send_pair(16'h0001, 16'h0000);                      // lowest nonzero date
        send_pair(16'h8000, 16'h0001);                      // top year bit alone
    endtask

    // Months 13..15 read as December; compare against December itself.
    task automatic test_month_clamp;
        send_pair(pack_date(5, 12, 10), 16'h0000);
        send_pair(pack_date(5, 13, 10), 16'h0000);
        send_pair(pack_date(5, 14, 10), 16'h0000);
        send_pair(pack_date(5, 15, 10), 16'h0000);
    endtask

    // Month zero and day zero read as 1; a day past the month end rolls over.
    task automatic test_day_edges;
        send_pair(pack_date(2, 0, 0), pack_time(1, 2, 3));
        send_pair(pack_date(1, 2, 31), 16'h0000);
        send_pair(pack_date(3, 4, 31), 16'h0000);
    endtask

    // Divisible by 4, by 100 and by 400: 1984, 2096 and 2000 leap, 2100 not.
    task automatic test_leap_rules;
        send_pair(pack_date(4, 3, 1), 16'h0000);
        send_pair(pack_date(20, 2, 29), 16'h0000);
        send_pair(pack_date(20, 3, 1), 16'h0000);
        send_pair(pack_date(116, 3, 1), 16'h0000);
        send_pair(pack_date(120, 3, 1), 16'h0000);
    endtask

    // Hour, minute and seconds fields go in unchecked.
    task automatic test_time_range;
        send_pair(pack_date(10, 6, 15), pack_time(31, 63, 31));
        send_pair(pack_date(10, 6, 15), pack_time(24, 60, 30));
    endtask

    // 2106-02-07 06:28:14 is the last FAT time whose count fits in 32 bits; two
    // seconds later the count wraps.
    task automatic test_wraparound;
        send_pair(pack_date(126, 2, 7), pack_time(6, 28, 7));
        send_pair(pack_date(126, 2, 7), pack_time(6, 28, 8));
    endtask

    // ---------------------------------------------------------------------
    // Random run: segments with differing idle levels; the final segments run
    // without idling on either side.
    // ---------------------------------------------------------------------
    task automatic test_random_pairs;
        int unsigned seg, k, pick;
        logic [15:0] date_w;
        for (seg = 0; seg < SEGMENT_COUNT; seg++) begin
            pick = $urandom_range(0, 2);
            if (seg >= SEGMENT_COUNT - QUIET_SEGMENTS || pick == 0) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (pick == 1) begin
                gap_pct   = 10;
                stall_pct = 5;
            end else begin
                gap_pct   = 40;
                stall_pct = 20;
            end
            for (k = 0; k < SEGMENT_LEN; k++) begin
                pick = $urandom_range(0, 15);
                if (pick == 0) begin
                    date_w = 16'h0000;
                end else if (pick < 9) begin
                    // Mostly calendar-valid dates with random contents.
                    date_w = pack_date($urandom_range(0, 127), $urandom_range(1, 12),
                                       $urandom_range(1, 31));
                end else begin
                    date_w = 16'($urandom_range(0, 16'hFFFF));
                end
                send_pair(date_w, 16'($urandom_range(0, 16'hFFFF)));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        // Hold reset, then release it at a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct   = 20;
        stall_pct = 10;
        test_zero_date();
        test_field_extremes();
        test_month_clamp();
        test_day_edges();
        test_leap_rules();
        test_time_range();
        test_wraparound();
        test_random_pairs();

        // Drop valid, drain what is outstanding, then give any stray
        // result time to show up.
        i_valid <= 1'b0;
        while (pending_epochs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
